### rtl/pkt_line_sideband_demux_macros.svh
// Assertion macros used by the checker of the pkt-line sideband demultiplexer.
`ifndef PKT_LINE_SIDEBAND_DEMUX_MACROS_SVH
`define PKT_LINE_SIDEBAND_DEMUX_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define PLS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pkt-line demux check failed");

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define PLS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pkt-line demux check failed");

`endif

### rtl/pls_pkg.sv
// Shared types and constants of the pkt-line sideband demultiplexer.
`default_nettype none
package pls_pkg;

	typedef enum logic [2:0] {
		KIND_DATA    = 3'd0,
		KIND_FLUSH   = 3'd1,
		KIND_EMPTY   = 3'd2,
		KIND_ERROR   = 3'd3,
		KIND_UNKNOWN = 3'd4
	} kind_t;

	localparam logic [7:0]  CH_PACK     = 8'd1;
	localparam logic [7:0]  CH_PROGRESS = 8'd2;
	localparam logic [15:0] HDR_LEN     = 16'd4;
	localparam logic [15:0] SB_MIN_LEN  = 16'd5;

	typedef struct packed {
		logic        emit;
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [1:0]  channel;
		logic        last_in_packet;
		logic [15:0] packet_length;
	} pls_result_t;

endpackage
`default_nettype wire

### rtl/pls_stream_if.sv
// Valid/ready channel interfaces for the input byte stream and the result stream.
`default_nettype none
interface pls_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface pls_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  out_byte;
	logic [1:0]  channel;
	logic        last_in_packet;
	logic [15:0] packet_length;

	modport source (output valid, output kind, output out_byte, output channel,
		output last_in_packet, output packet_length, input ready);
	modport sink (input valid, input kind, input out_byte, input channel,
		input last_in_packet, input packet_length, output ready);
endinterface
`default_nettype wire

### rtl/pls_parse.sv
// Frame parser: length decode, channel selection and payload tracking for one byte a cycle while step is high.
`default_nettype none
module pls_parse (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [7:0]         data_byte,
	input  wire logic               sideband_mode,
	output pls_pkg::pls_result_t    result
);
	import pls_pkg::*;

	typedef enum logic [1:0] {
		PH_LEN,
		PH_CHAN,
		PH_DATA,
		PH_SKIP
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [1:0]  digit_cnt_q, digit_cnt_n;
	logic [15:0] len_acc_q, len_acc_n;
	logic [15:0] remain_q, remain_n;
	logic [1:0]  chan_q, chan_n;

	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [15:0] acc_shift;
	logic        known_chan;
	logic        last_byte;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
			hex_val = 4'(data_byte - 8'h30);
		end else if (data_byte >= 8'h61 && data_byte <= 8'h66) begin
			hex_val = 4'(data_byte - 8'h57);
		end else if (data_byte >= 8'h41 && data_byte <= 8'h46) begin
			hex_val = 4'(data_byte - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign acc_shift  = {((digit_cnt_q == 2'd0) ? 12'h000 : len_acc_q[11:0]), hex_val};
	assign known_chan = (data_byte == CH_PACK) || (data_byte == CH_PROGRESS);
	assign last_byte  = (remain_q <= 16'd1);

	always_comb begin
		phase_n     = phase_q;
		digit_cnt_n = digit_cnt_q;
		len_acc_n   = len_acc_q;
		remain_n    = remain_q;
		chan_n      = chan_q;
		result      = '0;
		result.kind = KIND_DATA;
		unique case (phase_q)
			PH_LEN: begin
				if (!hex_ok) begin
					digit_cnt_n     = 2'd0;
					len_acc_n       = 16'd0;
					result.emit     = 1'b1;
					result.kind     = KIND_ERROR;
					result.out_byte = data_byte;
				end else if (digit_cnt_q != 2'd3) begin
					len_acc_n   = acc_shift;
					digit_cnt_n = digit_cnt_q + 2'd1;
				end else begin
					len_acc_n            = acc_shift;
					digit_cnt_n          = 2'd0;
					chan_n               = 2'd0;
					result.packet_length = acc_shift;
					if (acc_shift == 16'd0) begin
						result.emit          = 1'b1;
						result.kind          = KIND_FLUSH;
						result.packet_length = 16'd0;
					end else if (acc_shift < HDR_LEN) begin
						result.emit = 1'b1;
						result.kind = KIND_ERROR;
					end else if (sideband_mode) begin
						if (acc_shift == HDR_LEN) begin
							result.emit = 1'b1;
							result.kind = KIND_ERROR;
						end else begin
							remain_n = acc_shift - SB_MIN_LEN;
							phase_n  = PH_CHAN;
						end
					end else if (acc_shift == HDR_LEN) begin
						result.emit = 1'b1;
						result.kind = KIND_EMPTY;
					end else begin
						remain_n = acc_shift - HDR_LEN;
						phase_n  = PH_DATA;
					end
				end
			end
			PH_CHAN: begin
				result.packet_length = len_acc_q;
				if (known_chan) begin
					chan_n = data_byte[1:0];
					if (remain_q == 16'd0) begin
						phase_n        = PH_LEN;
						result.emit    = 1'b1;
						result.kind    = KIND_EMPTY;
						result.channel = data_byte[1:0];
					end else begin
						phase_n = PH_DATA;
					end
				end else begin
					chan_n          = 2'd0;
					phase_n         = (remain_q == 16'd0) ? PH_LEN : PH_SKIP;
					result.emit     = 1'b1;
					result.kind     = KIND_UNKNOWN;
					result.out_byte = data_byte;
				end
			end
			PH_DATA: begin
				remain_n              = remain_q - 16'd1;
				result.emit           = 1'b1;
				result.kind           = KIND_DATA;
				result.out_byte       = data_byte;
				result.channel        = chan_q;
				result.last_in_packet = last_byte;
				result.packet_length  = len_acc_q;
				if (last_byte) begin
					phase_n = PH_LEN;
				end
			end
			PH_SKIP: begin
				if (last_byte) begin
					remain_n = 16'd0;
					phase_n  = PH_LEN;
				end else begin
					remain_n = remain_q - 16'd1;
				end
			end
			default: begin
				phase_n = PH_LEN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEN;
			digit_cnt_q <= 2'd0;
			len_acc_q   <= 16'd0;
			remain_q    <= 16'd0;
			chan_q      <= 2'd0;
		end else if (step) begin
			phase_q     <= phase_n;
			digit_cnt_q <= digit_cnt_n;
			len_acc_q   <= len_acc_n;
			remain_q    <= remain_n;
			chan_q      <= chan_n;
		end
	end
endmodule
`default_nettype wire

### rtl/pkt_line_sideband_demux.sv
// Top level of the pkt-line deframer with sideband channel demultiplexing.
// Usage:
//   bytes_ch carries the raw framed stream, one byte per beat (valid/ready).
//   results carries at most one result beat per input byte: payload bytes,
//   flush markers, empty packets, framing errors and unknown-channel reports.
//   cfg_we/cfg_wdata write the sideband mode bit; it takes effect at the fourth
//   length digit of the next frame. Write it only while idle; not enforced.
// Timing:
//   A byte is registered at acceptance; its result is registered when the
//   parser steps, which a stalled results port holds back. One byte per cycle
//   is sustained while results is not stalled; the length and channel state
//   update is a single pass of logic between input and result registers.
// Reset and stall:
//   arst_n clears the mode bit, the parser state and both valid flags.
//   When results is stalled, the result holds and one more byte is taken into
//   the input register; bytes_ch.ready then drops until the result is taken.
`default_nettype none
module pkt_line_sideband_demux (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pls_byte_if.sink      bytes_ch,
	pls_result_if.source  results,
	input  wire logic     cfg_we,
	input  wire logic     cfg_wdata
);
	import pls_pkg::*;

	logic        sideband_mode_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        step;
	pls_result_t res;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  out_byte_q;
	logic [1:0]  channel_q;
	logic        last_q;
	logic [15:0] plen_q;

	assign advance        = !out_valid_q || results.ready;
	assign step           = valid_s1 && advance;
	assign bytes_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sideband_mode_q <= 1'b0;
		end else if (cfg_we) begin
			sideband_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes_ch.ready) begin
			valid_s1 <= bytes_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes_ch.ready && bytes_ch.valid) begin
			byte_s1 <= bytes_ch.data_byte;
		end
	end

	pls_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.data_byte     (byte_s1),
		.sideband_mode (sideband_mode_q),
		.result        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.emit) begin
			kind_q     <= res.kind;
			out_byte_q <= res.out_byte;
			channel_q  <= res.channel;
			last_q     <= res.last_in_packet;
			plen_q     <= res.packet_length;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.kind           = kind_q;
	assign results.out_byte       = out_byte_q;
	assign results.channel        = channel_q;
	assign results.last_in_packet = last_q;
	assign results.packet_length  = plen_q;
endmodule
`default_nettype wire

### rtl/pls_checker.sv
// Port-level checker for the pkt-line sideband demultiplexer and its bind.
`default_nettype none
`include "pkt_line_sideband_demux_macros.svh"
module pls_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  kind,
	input wire logic [1:0]  channel,
	input wire logic        last_in_packet
);
	import pls_pkg::*;

	`PLS_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid)
	`PLS_ASSERT_NOW(a_kind_legal, out_valid, kind <= 3'(KIND_UNKNOWN))
	`PLS_ASSERT_NOW(a_last_only_data, out_valid && kind != KIND_DATA, !last_in_packet)
	`PLS_ASSERT_NOW(a_channel_kind, out_valid && channel != 2'd0, kind == KIND_DATA || kind == KIND_EMPTY)
	`PLS_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
endmodule

bind pkt_line_sideband_demux pls_checker u_pls_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (bytes_ch.ready),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.kind           (results.kind),
	.channel        (results.channel),
	.last_in_packet (results.last_in_packet)
);
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pkt-line deframer with sideband channel demultiplexing.
module tb_top;
	import pls_pkg::*;

	typedef enum logic [1:0] {
		PARSE_LEN,
		PARSE_CHAN,
		PARSE_DATA,
		PARSE_SKIP
	} parse_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	pls_byte_if bytes_if ();
	pls_result_if res_if ();

	pkt_line_sideband_demux u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes_ch(bytes_if),
		.results(res_if),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	bit sb_mode = 1'b0;
	parse_phase_t parse_phase = PARSE_LEN;
	logic [1:0] digit_cnt = 2'd0;
	logic [15:0] len_acc = 16'd0;
	logic [15:0] remaining = 16'd0;
	logic [7:0] cur_chan = 8'd0;

	pls_result_t pending_results[$];
	int unsigned src_idle_pct = 16;
	int unsigned sink_idle_pct = 72;
	int unsigned sent_count = 0;
	int unsigned mismatch_count = 0;

	always #2 clk = ~clk;

	function automatic bit hex_nibble(input logic [7:0] b, output logic [3:0] val);
		bit ok;
		ok = 1'b1;
		if (b >= "0" && b <= "9") begin
			val = b[3:0];
		end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
			val = b[3:0] + 4'd9;
		end else begin
			val = 4'd0;
			ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic pls_result_t make_result(input kind_t k, input logic [7:0] b,
			input logic [1:0] ch, input logic last, input logic [15:0] plen);
		pls_result_t r;
		r.emit = 1'b1;
		r.kind = k;
		r.out_byte = b;
		r.channel = ch;
		r.last_in_packet = last;
		r.packet_length = plen;
		return r;
	endfunction

	function automatic pls_result_t deframe_byte(input logic [7:0] b);
		pls_result_t r;
		logic [3:0] nib;
		logic [15:0] plen;
		logic last;
		logic [1:0] chan;
		r = '0;
		plen = len_acc;
		case (parse_phase)
			PARSE_LEN: begin
				if (!hex_nibble(b, nib)) begin
					digit_cnt = 2'd0;
					len_acc = 16'd0;
					r = make_result(KIND_ERROR, b, 2'd0, 1'b0, 16'd0);
				end else begin
					len_acc = (digit_cnt == 2'd0) ? {12'd0, nib} : {len_acc[11:0], nib};
					if (digit_cnt != 2'd3) begin
						digit_cnt = digit_cnt + 2'd1;
					end else begin
						digit_cnt = 2'd0;
						cur_chan = 8'd0;
						if (len_acc == 16'd0) begin
							r = make_result(KIND_FLUSH, 8'd0, 2'd0, 1'b0, 16'd0);
						end else if (len_acc < HDR_LEN || (sb_mode && len_acc == HDR_LEN)) begin
							r = make_result(KIND_ERROR, 8'd0, 2'd0, 1'b0, len_acc);
						end else if (sb_mode) begin
							remaining = len_acc - SB_MIN_LEN;
							parse_phase = PARSE_CHAN;
						end else if (len_acc == HDR_LEN) begin
							r = make_result(KIND_EMPTY, 8'd0, 2'd0, 1'b0, len_acc);
						end else begin
							remaining = len_acc - HDR_LEN;
							parse_phase = PARSE_DATA;
						end
					end
				end
			end
			PARSE_CHAN: begin
				cur_chan = b;
				if (b == CH_PACK || b == CH_PROGRESS) begin
					if (remaining == 16'd0) begin
						parse_phase = PARSE_LEN;
						r = make_result(KIND_EMPTY, 8'd0, b[1:0], 1'b0, plen);
					end else begin
						parse_phase = PARSE_DATA;
					end
				end else begin
					parse_phase = (remaining == 16'd0) ? PARSE_LEN : PARSE_SKIP;
					r = make_result(KIND_UNKNOWN, b, 2'd0, 1'b0, plen);
				end
			end
			PARSE_DATA: begin
				last = (remaining <= 16'd1);
				chan = (cur_chan == CH_PACK || cur_chan == CH_PROGRESS) ? cur_chan[1:0] : 2'd0;
				remaining = remaining - 16'd1;
				if (last) begin
					parse_phase = PARSE_LEN;
				end
				r = make_result(KIND_DATA, b, chan, last, plen);
			end
			default: begin
				if (remaining <= 16'd1) begin
					remaining = 16'd0;
					parse_phase = PARSE_LEN;
				end else begin
					remaining = remaining - 16'd1;
				end
			end
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = "0" + {4'd0, n};
		end else begin
			c = (($urandom_range(0, 1) != 0) ? "a" : "A") + {4'd0, n} - 8'd10;
		end
		return c;
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] b;
		logic [3:0] nib;
		do b = 8'($urandom_range(0, 255)); while (hex_nibble(b, nib));
		return b;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_results
		pls_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("kind of a result with nothing pending",
					16'(res_if.kind), 16'd0);
			end else begin
				want = pending_results.pop_front();
				if (res_if.kind !== want.kind)
					report_mismatch("kind", 16'(res_if.kind), 16'(want.kind));
				if (res_if.out_byte !== want.out_byte)
					report_mismatch("out_byte", 16'(res_if.out_byte), 16'(want.out_byte));
				if (res_if.channel !== want.channel)
					report_mismatch("channel", 16'(res_if.channel), 16'(want.channel));
				if (res_if.last_in_packet !== want.last_in_packet)
					report_mismatch("last_in_packet", 16'(res_if.last_in_packet),
						16'(want.last_in_packet));
				if (res_if.packet_length !== want.packet_length)
					report_mismatch("packet_length", res_if.packet_length, want.packet_length);
			end
		end
		res_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		pls_result_t r;
		gap = 0;
		while ($urandom_range(0, 99) < src_idle_pct) gap++;
		if (gap != 0) begin
			bytes_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bytes_if.valid <= 1'b1;
		bytes_if.data_byte <= b;
		// The beat is taken at the first edge that sees ready high.
		do @(posedge clk); while (!bytes_if.ready);
		r = deframe_byte(b);
		if (r.emit) begin
			pending_results.insert(pending_results.size(), r);
		end
		sent_count++;
	endtask

	task automatic send_length(input logic [15:0] len);
		for (int i = 3; i >= 0; i--) send_byte(hex_char(len[i*4 +: 4]));
	endtask

	task automatic send_frame(input logic [15:0] len, input logic [7:0] chan_byte);
		int unsigned n;
		send_length(len);
		n = (len > HDR_LEN) ? len - HDR_LEN : 0;
		if (sb_mode && n != 0) begin
			send_byte(chan_byte);
			n--;
		end
		repeat (n) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic drain_results();
		bytes_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input bit m);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb_mode = m;
	endtask

	task automatic test_plain_frames();
		send_length(16'h0000);
		send_length(16'h0004);
		send_length(16'h0003);
		send_byte("1");
		send_byte(":");
		send_byte("/");
		send_byte("F");
		send_byte("g");
		send_byte("0");
		send_byte("0");
		send_byte("0");
		send_byte("6");
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	task automatic test_sideband_frames();
		write_mode(1'b1);
		send_length(16'h0004);
		send_frame(16'h0005, CH_PACK);
		send_frame(16'h0005, 8'h00);
		send_frame(16'h0007, 8'hFF);
		send_byte("0");
		send_byte("0");
		send_byte("0");
		send_byte("a");
		send_byte(CH_PROGRESS);
		repeat (5) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic test_mode_change_mid_frame();
		write_mode(1'b0);
		send_length(16'h0008);
		send_byte(8'h01);
		send_byte(8'h80);
		write_mode(1'b1);
		send_byte(8'h7F);
		send_byte(8'h02);
		send_frame(16'h0006, CH_PROGRESS);
	endtask

	task automatic test_random_stream(input int unsigned n_bytes);
		int unsigned stop_at;
		int unsigned pick;
		logic [15:0] len;
		logic [7:0] chan;
		stop_at = sent_count + n_bytes;
		while (sent_count < stop_at) begin
			pick = $urandom_range(0, 99);
			chan = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, 2))
				: 8'($urandom_range(0, 255));
			if (pick < 70) begin
				len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(5, 260))
					: 16'($urandom_range(4, 20));
				send_frame(len, chan);
			end else if (pick < 78) begin
				send_frame(16'h0000, chan);
			end else if (pick < 86) begin
				send_frame(16'($urandom_range(1, 5)), chan);
			end else if (pick < 94) begin
				repeat ($urandom_range(0, 3)) send_byte(hex_char(4'($urandom_range(0, 15))));
				send_byte(non_hex_byte());
			end else begin
				repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
				send_byte(non_hex_byte());
			end
		end
	endtask

	initial begin
		bytes_if.valid = 1'b0;
		bytes_if.data_byte = 8'd0;
		res_if.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_frames();
		test_sideband_frames();
		test_mode_change_mid_frame();
		write_mode(1'b0);
		test_random_stream(270);

		src_idle_pct = 72;
		sink_idle_pct = 16;
		write_mode(1'b1);
		test_random_stream(270);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		write_mode(1'b0);
		test_random_stream(130);
		write_mode(1'b1);
		test_random_stream(130);

		drain_results();
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#(4_000_000);
		$display("== FAIL ==");
		$finish;
	end

endmodule
